[hw/rtl/psf_pkg.sv]
// Shared types and constants for the PNG scanline filter.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package psf_pkg;

    localparam int DATA_W       = 8;
    localparam int CFG_W        = 10;
    localparam int CFG_IDX_W    = 2;
    localparam int MODE_W       = 2;
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int OQ_DEPTH     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd2;

    localparam logic [MODE_W-1:0] FILT_NONE = 2'd0;
    localparam logic [MODE_W-1:0] FILT_SUB  = 2'd1;
    localparam logic [MODE_W-1:0] FILT_UP   = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              is_row_tag;
        logic              last;
        logic              image_end;
    } t_psf_word;

endpackage

[hw/rtl/psf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Read-first on a same-address write. No dependencies.
`timescale 1ns / 1ps

module psf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/png_scanline_filter.sv]
// PNG scanline filter top level: counters, predictor stage and output queue.
// Depends on psf_pkg and psf_ram (line store for the row above).
//
// Accepts one 8-bit indexed pixel per cycle while o_stall is low, in raster
// order, and emits the filtered PNG scanline stream: the filter type byte at
// the start of each row, then each pixel minus its predictor modulo 256 (None,
// Sub or Up). A pixel is held in the predictor stage registers while the line
// store read completes, is then written into the output queue, and can leave
// the queue from there. Each row takes one extra output slot for the tag word.
// A four-word output queue decouples the two sides. Configuration must be
// written only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module png_scanline_filter
    import psf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [DATA_W-1:0]    i_pixel,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DATA_W-1:0]    o_out_byte,
    output logic                 o_is_row_tag,
    output logic                 o_last,
    output logic                 o_image_end
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MW  = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                         $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
    localparam int GW  = (MW + 1 > CFG_W) ? MW + 1 : CFG_W;
    localparam int QAW = $clog2(OQ_DEPTH);
    localparam int QCW = $clog2(OQ_DEPTH + 1);
    localparam int QSW = QCW + 1;

    localparam logic [GW-1:0] G_MAX_W = GW'(MAX_WIDTH);
    localparam logic [GW-1:0] G_MAX_H = GW'(MAX_HEIGHT);
    localparam logic [GW-1:0] G_ONE   = GW'(1);

    logic [CFG_W-1:0]  r_cfg_width;
    logic [CFG_W-1:0]  r_cfg_height;
    logic [MODE_W-1:0] r_cfg_mode;

    logic [CW-1:0]     r_column, n_column;
    logic [RW-1:0]     r_row, n_row;
    logic [DATA_W-1:0] r_left;

    logic              r_s1_valid;
    logic              r_s1_tag;
    logic              r_s1_up;
    logic              r_s1_end;
    logic [MODE_W-1:0] r_s1_mode;
    logic [DATA_W-1:0] r_s1_px;
    logic [DATA_W-1:0] r_s1_pred;

    t_psf_word         r_oq [OQ_DEPTH];
    logic [QAW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0]    r_oq_count;

    logic [GW-1:0]     w_eff, h_eff, col_inc, row_inc, cfg_w_g, cfg_h_g;
    logic [MODE_W-1:0] mode_eff;
    logic              accept, col_zero, row_wrap, img_wrap;
    logic [DATA_W-1:0] up_data, s1_pred;
    logic [QSW-1:0]    pending, room_need;
    logic              pop;
    t_psf_word         tag_word, px_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_W'(1);
            r_cfg_height <= CFG_W'(1);
            r_cfg_mode   <= FILT_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                REG_FILTER_MODE:  r_cfg_mode   <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_w_g  = GW'(r_cfg_width);
    assign cfg_h_g  = GW'(r_cfg_height);
    assign w_eff    = (cfg_w_g == '0) ? G_ONE : ((cfg_w_g > G_MAX_W) ? G_MAX_W : cfg_w_g);
    assign h_eff    = (cfg_h_g == '0) ? G_ONE : ((cfg_h_g > G_MAX_H) ? G_MAX_H : cfg_h_g);
    assign mode_eff = (r_cfg_mode == FILT_SUB || r_cfg_mode == FILT_UP) ? r_cfg_mode
                                                                        : FILT_NONE;

    assign pending   = r_s1_valid ? (r_s1_tag ? QSW'(2) : QSW'(1)) : '0;
    assign room_need = QSW'(r_oq_count) + pending + QSW'(2);
    assign o_stall   = (room_need > QSW'(OQ_DEPTH));
    assign accept    = i_valid && !o_stall;

    assign col_zero = (r_column == '0);
    assign col_inc  = GW'(r_column) + G_ONE;
    assign row_inc  = GW'(r_row) + G_ONE;
    assign row_wrap = (col_inc >= w_eff);
    assign img_wrap = row_wrap && (row_inc >= h_eff);

    always_comb begin
        n_column = r_column;
        n_row    = r_row;
        if (accept) begin
            if (row_wrap) begin
                n_column = '0;
                n_row    = img_wrap ? '0 : RW'(row_inc);
            end else begin
                n_column = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column   <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_column   <= n_column;
            r_row      <= n_row;
            r_s1_valid <= accept;
            if (accept) begin
                r_left <= i_pixel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_tag  <= col_zero;
            r_s1_up   <= (mode_eff == FILT_UP) && (r_row != '0);
            r_s1_end  <= img_wrap;
            r_s1_mode <= mode_eff;
            r_s1_px   <= i_pixel;
            r_s1_pred <= ((mode_eff == FILT_SUB) && !col_zero) ? r_left : '0;
        end
    end

    psf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_column),
        .i_wdata (i_pixel),
        .i_re    (accept),
        .i_raddr (r_column),
        .o_rdata (up_data)
    );

    assign s1_pred = r_s1_up ? up_data : r_s1_pred;

    always_comb begin
        tag_word.out_byte   = DATA_W'(r_s1_mode);
        tag_word.is_row_tag = 1'b1;
        tag_word.last       = 1'b0;
        tag_word.image_end  = 1'b0;
        px_word.out_byte    = r_s1_px - s1_pred;
        px_word.is_row_tag  = 1'b0;
        px_word.last        = 1'b1;
        px_word.image_end   = r_s1_end;
    end

    assign pop = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            if (r_s1_tag) begin
                r_oq[r_wr_ptr]         <= tag_word;
                r_oq[r_wr_ptr + 1'b1]  <= px_word;
            end else begin
                r_oq[r_wr_ptr]         <= px_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_oq_count <= '0;
        end else begin
            r_wr_ptr   <= r_wr_ptr + QAW'(pending);
            r_rd_ptr   <= r_rd_ptr + QAW'(pop);
            r_oq_count <= QCW'(QSW'(r_oq_count) + pending - QSW'(pop));
        end
    end

    assign o_valid      = (r_oq_count != '0);
    assign o_out_byte   = r_oq[r_rd_ptr].out_byte;
    assign o_is_row_tag = r_oq[r_rd_ptr].is_row_tag;
    assign o_last       = r_oq[r_rd_ptr].last;
    assign o_image_end  = r_oq[r_rd_ptr].image_end;

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (QSW'(r_oq_count) + pending) <= QSW'(OQ_DEPTH))
        else $error("output queue overflow");

    a_row_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && col_zero) |=> (r_s1_valid && r_s1_tag))
        else $error("row start without tag word");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_image_end) |-> (o_last && !o_is_row_tag))
        else $error("image end on a non-pixel word");

endmodule

[tb/sv/psf_stream_checker.sv]
// Scoreboard for png_scanline_filter: mirrors register writes, predicts filtered words.
// Compares every accepted output word in order. Depends on psf_pkg.
`timescale 1ns / 1ps

module psf_stream_checker
    import psf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [DATA_W-1:0]    i_pixel,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [DATA_W-1:0]    i_out_byte,
    input  logic                 i_is_row_tag,
    input  logic                 i_last,
    input  logic                 i_image_end,
    output int                   o_mismatches,
    output int                   o_pending
);

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [MODE_W-1:0] mode_reg;

    int                col;
    int                row;
    logic [DATA_W-1:0] left_px;
    logic [DATA_W-1:0] row_above [DEF_MAX_WIDTH];

    t_psf_word         filtered_words [$];
    int                mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic int clamp_size(input int v, input int max_v);
        if (v == 0) return 1;
        if (v > max_v) return max_v;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic filter_pixel(input logic [DATA_W-1:0] px);
        int                w;
        int                h;
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] pred;
        logic              img_end;
        t_psf_word         wd;
        w = clamp_size(int'(width_reg), DEF_MAX_WIDTH);
        h = clamp_size(int'(height_reg), DEF_MAX_HEIGHT);
        mode = (mode_reg == FILT_SUB || mode_reg == FILT_UP) ? mode_reg : FILT_NONE;
        pred = '0;
        img_end = 1'b0;
        if (col == 0) begin
            wd.out_byte   = {{(DATA_W-MODE_W){1'b0}}, mode};
            wd.is_row_tag = 1'b1;
            wd.last       = 1'b0;
            wd.image_end  = 1'b0;
            filtered_words = {filtered_words, wd};
        end
        case (mode)
            FILT_SUB: begin
                if (col != 0) pred = left_px;
            end
            FILT_UP: begin
                if (row != 0) pred = row_above[col];
            end
            default: ;
        endcase
        row_above[col] = px;
        left_px = px;
        if (col + 1 >= w) begin
            col = 0;
            if (row + 1 >= h) begin
                row = 0;
                img_end = 1'b1;
            end else begin
                row = row + 1;
            end
        end else begin
            col = col + 1;
        end
        wd.out_byte   = px - pred;
        wd.is_row_tag = 1'b0;
        wd.last       = 1'b1;
        wd.image_end  = img_end;
        filtered_words = {filtered_words, wd};
    endtask

    task automatic compare_word(input t_psf_word exp_wd);
        if (i_out_byte !== exp_wd.out_byte)
            report_mismatch($sformatf("out_byte got %02h expected %02h",
                                      i_out_byte, exp_wd.out_byte));
        if (i_is_row_tag !== exp_wd.is_row_tag)
            report_mismatch($sformatf("is_row_tag got %b expected %b",
                                      i_is_row_tag, exp_wd.is_row_tag));
        if (i_last !== exp_wd.last)
            report_mismatch($sformatf("last got %b expected %b", i_last, exp_wd.last));
        if (i_image_end !== exp_wd.image_end)
            report_mismatch($sformatf("image_end got %b expected %b",
                                      i_image_end, exp_wd.image_end));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = 10'd1;
            height_reg = 10'd1;
            mode_reg   = FILT_NONE;
            col        = 0;
            row        = 0;
            left_px    = '0;
            filtered_words.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (filtered_words.size() == 0) begin
                    report_mismatch($sformatf("word %02h with nothing expected", i_out_byte));
                end else begin
                    compare_word(filtered_words.pop_front());
                end
            end
            if (i_in_valid && !i_in_stall) begin
                filter_pixel(i_pixel);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  = i_cfg_data;
                    REG_IMAGE_HEIGHT: height_reg = i_cfg_data;
                    REG_FILTER_MODE:  mode_reg   = i_cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end
            o_pending <= filtered_words.size();
        end
    end

endmodule

[tb/sv/tb_png_scanline_filter.sv]
// Testbench top for png_scanline_filter: clock, reset, pixel stimulus and verdict.
// Depends on psf_pkg, the block and psf_stream_checker.
`timescale 1ns / 1ps

module tb_png_scanline_filter;
    import psf_pkg::*;

    localparam int                   WATCHDOG_LIMIT = 4000;
    localparam int                   DRAIN_PAUSE    = 6;
    localparam int                   STAGE_ITEMS    = 390;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 2'd3;
    localparam logic [MODE_W-1:0]    FILT_RESERVED  = 2'd3;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0]     cfg_data   = '0;
    logic                 pix_valid  = 1'b0;
    logic                 pix_stall;
    logic [DATA_W-1:0]    pixel      = '0;
    logic                 word_valid;
    logic                 word_stall = 1'b0;
    logic [DATA_W-1:0]    out_byte;
    logic                 is_row_tag;
    logic                 last_flag;
    logic                 image_end;

    int send_idle_pct = 20;
    int recv_idle_pct = 83;
    int quiet_cycles  = 0;
    int mismatches;
    int pending;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    png_scanline_filter DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_valid      (pix_valid),
        .o_stall      (pix_stall),
        .i_pixel      (pixel),
        .o_valid      (word_valid),
        .i_stall      (word_stall),
        .o_out_byte   (out_byte),
        .o_is_row_tag (is_row_tag),
        .o_last       (last_flag),
        .o_image_end  (image_end)
    );

    psf_stream_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (pix_valid),
        .i_in_stall   (pix_stall),
        .i_pixel      (pixel),
        .i_out_valid  (word_valid),
        .i_out_stall  (word_stall),
        .i_out_byte   (out_byte),
        .i_is_row_tag (is_row_tag),
        .i_last       (last_flag),
        .i_image_end  (image_end),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        word_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (pix_valid && !pix_stall) || (word_valid && !word_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [DATA_W-1:0] px);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pixel     <= px;
        do @(posedge clk); while (pix_stall);
    endtask

    task automatic wait_for_drain();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input logic [MODE_W-1:0] mode);
        logic [CFG_W-1:0] mode_word;
        mode_word = CFG_W'($urandom_range(0, 1023));
        mode_word[MODE_W-1:0] = mode;
        wait_for_drain();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_FILTER_MODE, mode_word);
        write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 1023)));
        cfg_we <= 1'b0;
    endtask

    task automatic send_random(input int n);
        repeat (n) send_pixel(DATA_W'($urandom_range(0, 255)));
    endtask

    task automatic run_random_stage(input int s_pct, input int r_pct);
        int                sent;
        int                w;
        int                h;
        int                w_raw;
        int                h_raw;
        int                n;
        int                sz;
        logic [MODE_W-1:0] mode;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < STAGE_ITEMS) begin
            sz = $urandom_range(0, 99);
            if (sz < 75) begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
            end else if (sz < 95) begin
                w = $urandom_range(9, 48);
                h = $urandom_range(1, 4);
            end else begin
                w = $urandom_range(49, 512);
                h = 1;
            end
            w_raw = w;
            h_raw = h;
            if (w == 1 && $urandom_range(0, 1) == 1) w_raw = 0;
            if (h == 1 && $urandom_range(0, 1) == 1) h_raw = 0;
            if (w >= 256 && $urandom_range(0, 1) == 1) begin
                w     = 512;
                w_raw = $urandom_range(513, 1023);
            end
            mode = MODE_W'($urandom_range(0, 3));
            apply_config(CFG_W'(w_raw), CFG_W'(h_raw), mode);
            n = (w * h <= 64) ? w * h * $urandom_range(1, 4) : w * h;
            if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
            repeat (n) begin
                if ($urandom_range(0, 199) == 0) wait_for_drain();
                send_pixel(DATA_W'($urandom_range(0, 255)));
            end
            sent += n;
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: every pixel is a one-pixel image
        send_pixel(8'h00);
        send_pixel(8'hFF);

        apply_config(10'd3, 10'd2, FILT_SUB);
        send_pixel(8'h05);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'h01);
        send_pixel(8'h80);

        apply_config(10'd3, 10'd2, FILT_UP);
        send_pixel(8'h10);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h00);
        send_pixel(8'h00);
        send_pixel(8'hFF);

        apply_config(10'd2, 10'd1, FILT_RESERVED);
        send_pixel(8'h55);
        send_pixel(8'hAA);

        // shrink geometry mid image: both counters pass the new last index
        apply_config(10'd4, 10'd3, FILT_UP);
        send_pixel(8'h20);
        send_pixel(8'h7F);
        send_pixel(8'h80);
        send_pixel(8'hC3);
        send_pixel(8'h1F);
        send_pixel(8'h80);
        send_pixel(8'h3C);
        apply_config(10'd2, 10'd1, FILT_UP);
        send_pixel(8'hE0);

        // oversized registers saturate; the full-width row fills the line store
        apply_config(10'h3FF, 10'h3FF, FILT_UP);
        send_random(DEF_MAX_WIDTH + 40);
        apply_config(10'd40, 10'd1, FILT_UP);
        send_random(1);

        apply_config(10'd1, 10'h3FF, FILT_SUB);
        send_random(30);
        apply_config(10'd1, 10'd0, FILT_SUB);
        send_random(1);

        apply_config(10'd0, 10'd3, FILT_NONE);
        send_random(3);

        run_random_stage(20, 83);
        run_random_stage(83, 20);
        run_random_stage(0, 0);

        wait_for_drain();
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/psf_pkg.sv
hw/rtl/psf_ram.sv
hw/rtl/png_scanline_filter.sv
tb/sv/psf_stream_checker.sv
tb/sv/tb_png_scanline_filter.sv
